FILE: design/range_chmin_add_history_max_array_assert.svh
// Assertion macros used by the checker of the historic-maximum array.
// The included text is compiled only once.
`ifndef RANGE_CHMIN_ADD_HISTORY_MAX_ARRAY_ASSERT_SVH
`define RANGE_CHMIN_ADD_HISTORY_MAX_ARRAY_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent; this is not checked in reset.
`define RCHM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent; this is not checked in reset.
`define RCHM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// This one is checked in reset as well.
`define RCHM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rchm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchm_pkg
// Types and constants for the historic-maximum array and its cell row.
// ----------------------------------------------------------------------------
package rchm_pkg;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_QMAX  = 3'd1,
    MODE_QSUM  = 3'd2,
    MODE_CHMIN = 3'd3,
    MODE_LOAD  = 3'd4
  } mode_t;

  // Starting value for a max query over an empty range.
  localparam logic signed [63:0] EMPTY_MAX = -64'sd1000000000000000000;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         start;
    logic [7:0]         stop;
    logic signed [63:0] x;
  } op_t;

  // One stage of the row: an operation in flight and its running answer.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic signed [63:0] acc;
  } link_t;

endpackage

FILE: design/rchm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchm_if
// Valid/ready channels for operations in and answers out.
// ----------------------------------------------------------------------------
interface rchm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [7:0]         range_start;
  logic [7:0]         range_end;
  logic signed [63:0] operand_value;

  modport source (output valid, mode, range_start, range_end, operand_value, input ready);
  modport sink (input valid, mode, range_start, range_end, operand_value, output ready);
endinterface

interface rchm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] answer;

  modport source (output valid, answer, input ready);
  modport sink (input valid, answer, output ready);
endinterface

FILE: design/range_chmin_add_history_max_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_chmin_add_history_max_array
// Array of values with historic maxima: range add, range chmin, max query,
// historic-maximum sum query and element load, in a row of element cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | role
//  req     | in  | mode, range_start, range_end, operand_value    | operations
//  rsp     | out | answer                                         | one per operation
//
// Each operation enters cell 0 and moves one cell per cycle unless rsp stalls;
// its answer leaves the last cell. One transaction per cycle is taken in steady
// state unless rsp stalls, as the row holds ELEMENTS operations at once.
// Reset clears every element, both values and history.
// A result held on rsp freezes the whole row, and req.ready drops with it.
module range_chmin_add_history_max_array #(
  parameter int ELEMENTS = 128
) (
  input logic       clk,
  input logic       rst,
  rchm_req_if.sink  req,
  rchm_rsp_if.source rsp
);
  import rchm_pkg::*;

  localparam int CW = ($clog2(ELEMENTS) + 1 > 8) ? $clog2(ELEMENTS) + 1 : 8;

  link_t links [ELEMENTS + 1];
  logic  advance;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  assign links[0].valid    = req.valid;
  assign links[0].op.mode  = req.mode;
  assign links[0].op.start = req.range_start;
  assign links[0].op.stop  = req.range_end;
  assign links[0].op.x     = req.operand_value;
  assign links[0].acc      = (req.mode == MODE_QMAX) ? EMPTY_MAX : 64'sd0;

  for (genvar g = 0; g < ELEMENTS; g++) begin : g_cell
    rchm_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .link_in  (links[g]),
      .link_out (links[g + 1])
    );
  end

  assign rsp.valid  = links[ELEMENTS].valid;
  assign rsp.answer = links[ELEMENTS].acc;

endmodule

FILE: design/rchm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchm_cell
// One element of the array: holds its current value and historic maximum,
// applies each passing operation and forwards it with the updated answer.
// ----------------------------------------------------------------------------
module rchm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rchm_pkg::link_t link_in,
  output rchm_pkg::link_t link_out
);
  import rchm_pkg::*;

  logic signed [63:0] cur;
  logic signed [63:0] hist;
  logic signed [63:0] cur_next;
  logic signed [63:0] hist_next;
  logic signed [63:0] acc_next;
  logic signed [63:0] upd;
  logic [CW-1:0]      idx_c;
  logic [CW-1:0]      start_c;
  logic [CW-1:0]      stop_c;
  logic               in_range;
  logic               hit_load;

  logic               out_valid;
  op_t                out_op;
  logic signed [63:0] out_acc;

  assign idx_c    = CW'(IDX);
  assign start_c  = CW'(link_in.op.start);
  assign stop_c   = CW'(link_in.op.stop);
  // The cell index is always inside the array, so clamping the ends is implicit.
  assign in_range = (idx_c >= start_c) && (idx_c < stop_c);
  assign hit_load = (idx_c == start_c);

  always_comb begin
    cur_next  = cur;
    hist_next = hist;
    acc_next  = link_in.acc;
    upd       = cur;
    case (mode_t'(link_in.op.mode))
      MODE_ADD: begin
        upd = cur + link_in.op.x;
        if (in_range) begin
          cur_next  = upd;
          hist_next = (hist < upd) ? upd : hist;
        end
      end
      MODE_CHMIN: begin
        upd = (link_in.op.x < cur) ? link_in.op.x : cur;
        if (in_range) begin
          cur_next  = upd;
          hist_next = (hist < upd) ? upd : hist;
        end
      end
      MODE_QMAX: begin
        if (in_range && (link_in.acc < cur)) begin
          acc_next = cur;
        end
      end
      MODE_QSUM: begin
        if (in_range) begin
          acc_next = link_in.acc + hist;
        end
      end
      MODE_LOAD: begin
        if (hit_load) begin
          cur_next  = link_in.op.x;
          hist_next = link_in.op.x;
        end
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      hist      <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= link_in.valid;
      if (link_in.valid) begin
        cur  <= cur_next;
        hist <= hist_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_op  <= link_in.op;
      out_acc <= acc_next;
    end
  end

  assign link_out = '{valid: out_valid, op: out_op, acc: out_acc};

endmodule

FILE: design/rchm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchm_checker
// Port-level checks on the historic-maximum array, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_chmin_add_history_max_array_assert.svh"

module rchm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_answer
);

  // The row moves only when the output slot is free or being emptied.
  `RCHM_ASSERT_NOW(a_ready_follows_output, clk, rst, 1'b1,
                   req_ready == (!rsp_valid || rsp_ready),
                   "req.ready does not track the output slot")

  `RCHM_ASSERT_NEXT(a_rsp_valid_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid,
                    "rsp.valid dropped while stalled")

  `RCHM_ASSERT_NEXT(a_rsp_answer_holds, clk, rst, rsp_valid && !rsp_ready,
                    $stable(rsp_answer), "rsp.answer changed while stalled")

  // Reset empties the row, so no answer can be offered right after it.
  `RCHM_ASSERT_ALWAYS_NEXT(a_no_rsp_after_reset, clk, rst, !rsp_valid,
                           "answer offered right after reset")

endmodule

bind range_chmin_add_history_max_array rchm_checker u_rchm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_answer (rsp.answer)
);
